// ----- src/dqps_pkg.sv -----
// Package for the double-ended queue with parity split.
// Holds widths, command and status codes, and the result word type.
// No dependencies.
package dqps_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int WORD_W      = 32;
  localparam int MODE_W      = 3;
  localparam int PART_W      = 2;
  localparam int STAT_W      = 3;
  localparam int TUSER_IN_W  = 8;
  localparam int TUSER_OUT_W = 8;

  // command codes
  localparam logic [MODE_W-1:0] MODE_CREATE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_VIEW_FWD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VIEW_BACK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SPLIT      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NONE       = 3'd7;

  // part codes
  localparam logic [PART_W-1:0] PART_WHOLE = 2'd0;
  localparam logic [PART_W-1:0] PART_EVEN  = 2'd1;
  localparam logic [PART_W-1:0] PART_ODD   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_ITEM      = 3'd0;
  localparam logic [STAT_W-1:0] ST_OK        = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOCREATE  = 3'd4;

  // one result word
  typedef struct packed {
    logic signed [WORD_W-1:0] item;
    logic [PART_W-1:0]        part;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } res_t;

endpackage

// ----- src/dqps_mem.sv -----
// Entry store of the queue: one write port, one read port with registered data.
// Depends on dqps_pkg.
module dqps_mem
  import dqps_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WORD_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WORD_W-1:0]        rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dqps_out.sv -----
// Output register stage: holds one result word until the sink takes it.
// Depends on dqps_pkg.
module dqps_out
  import dqps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  res_t       res_i,
  output logic       res_free_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output res_t       m_res_o
);

  logic out_valid_q, out_valid_d;
  res_t out_q;
  logic load;

  assign res_free_o = !out_valid_q || m_ready_i;
  assign load       = res_valid_i && res_free_o;

  // valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_i;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

endmodule

// ----- src/dqps_seq.sv -----
// Command sequencer: queue pointers, entry walk over the store, split packing
// and result ordering through a one-word pending buffer. Depends on dqps_pkg.
module dqps_seq
  import dqps_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [WORD_W-1:0]        value_i,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [WORD_W-1:0]        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  logic [WORD_W-1:0]        mem_rdata_i,
  output logic                     res_valid_o,
  output res_t                     res_o,
  input  logic                     res_free_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic              created_q, created_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     kept_q, kept_d;
  logic [MODE_W-1:0] op_q, op_d;
  logic              pass2_q, pass2_d;
  res_t              pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;

  logic is_split, is_odd, cand_en, flush, go, at_end, odd_keep;
  logic [PART_W-1:0] cand_part;
  logic [CW-1:0]     count_m1;

  // circular index: base + off, both below DEPTH
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign count_m1  = count_q - CW'(1);
  assign is_split  = (op_q == MODE_SPLIT);
  assign is_odd    = mem_rdata_i[0];
  assign cand_en   = !is_split || (pass2_q ? is_odd : !is_odd);
  assign cand_part = !is_split ? PART_WHOLE : (pass2_q ? PART_ODD : PART_EVEN);
  assign odd_keep  = is_split && pass2_q && is_odd;
  assign flush     = (state_q == S_EV) && cand_en && pend_vld_q;
  assign go        = !flush || res_free_i;
  assign at_end    = pass2_q ? (idx_q == count_m1) : (idx_q == CW'(0));

  // next-state and datapath control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    created_d   = created_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    op_d        = op_q;
    pass2_d     = pass2_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot(head_q, count_q[AW-1:0]);
    mem_wdata_o = value_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot(head_q, idx_q[AW-1:0]);
    res_valid_o = 1'b0;
    res_o       = pend_q;
    res_o.last  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pend_d = '{item: '0, part: PART_WHOLE, status: ST_OK, last: 1'b0};
          case (mode_i)
            MODE_CREATE: begin
              head_d      = '0;
              count_d     = CW'(1);
              created_d   = 1'b1;
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              pend_vld_d  = 1'b1;
              state_d     = S_FIN;
            end
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              pend_vld_d = 1'b1;
              state_d    = S_FIN;
              if (!created_q) begin
                pend_d.status = ST_NOCREATE;
              end else if (count_q >= CW'(DEPTH)) begin
                pend_d.status = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
                if (mode_i == MODE_PUSH_FRONT) begin
                  head_d      = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
                  mem_waddr_o = head_d;
                end
              end
            end
            MODE_VIEW_FWD, MODE_VIEW_BACK, MODE_SPLIT: begin
              if (count_q == '0) begin
                pend_d.status = ST_EMPTY;
                pend_vld_d    = 1'b1;
                state_d       = S_FIN;
              end else begin
                op_d    = mode_i;
                pass2_d = (mode_i == MODE_VIEW_FWD);
                idx_d   = (mode_i == MODE_VIEW_FWD) ? '0 : count_m1;
                kept_d  = '0;
                state_d = S_RD;
              end
            end
            MODE_CLEAR: begin
              pend_vld_d = 1'b1;
              state_d    = S_FIN;
              if (count_q == '0) begin
                pend_d.status = ST_EMPTY;
              end else begin
                count_d   = '0;
                head_d    = '0;
                created_d = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_EV;
      end

      S_EV: begin
        // older pending word leaves first, with last cleared
        res_valid_o = flush;
        if (go) begin
          if (cand_en) begin
            pend_d     = '{item: mem_rdata_i, part: cand_part, status: ST_ITEM,
                           last: 1'b0};
            pend_vld_d = 1'b1;
          end
          // pack odd entries forward from head
          if (odd_keep) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = slot(head_q, kept_q[AW-1:0]);
            mem_wdata_o = mem_rdata_i;
            kept_d      = kept_q + CW'(1);
          end
          if (!at_end) begin
            idx_d   = pass2_q ? idx_q + CW'(1) : idx_q - CW'(1);
            state_d = S_RD;
          end else if (is_split && !pass2_q) begin
            pass2_d = 1'b1;
            idx_d   = '0;
            state_d = S_RD;
          end else begin
            if (is_split) begin
              count_d = kept_d;
            end
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        if (res_free_i) begin
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      created_q  <= 1'b0;
      idx_q      <= '0;
      kept_q     <= '0;
      op_q       <= MODE_NONE;
      pass2_q    <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      created_q  <= created_d;
      idx_q      <= idx_d;
      kept_q     <= kept_d;
      op_q       <= op_d;
      pass2_q    <= pass2_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // pending word payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH) && {1'b0, head_q} < (AW+1)'(DEPTH))
    else $error("queue pointers out of range");

  a_fin_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> pend_vld_q)
    else $error("final word missing");

  a_pack_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV && is_split && pass2_q) |-> kept_q <= idx_q)
    else $error("split packing overtook the read index");

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && mode_i != MODE_NONE) |=> state_q != S_IDLE)
    else $error("command accepted but sequencer stayed idle");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q)
    else $error("pending word left behind in idle");

endmodule

// ----- src/deque_with_parity_split_core.sv -----
// Double-ended queue of signed 32-bit words with parity split.
// Sequence: a status command goes from accept to S_FIN, which offers its word to the
// output stage; a view reads (S_RD) and evaluates (S_EV) each entry in turn, and a split
// walks the entries twice. The output stage can stall the sequencer in S_EV and S_FIN.
// Throughput: one command at a time; input ready only while the sequencer idles.
// Reset (rst_ni low, async): queue empty, not created; the store is not cleared.
module deque_with_parity_split_core
  import dqps_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [WORD_W-1:0]      s_axis_tdata_i,   // [31:0] value
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser_i,   // [2:0] mode, rest zero
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [WORD_W-1:0]      m_axis_tdata_o,   // [31:0] item
  output logic [TUSER_OUT_W-1:0] m_axis_tuser_o,   // [1:0] part, [4:2] status, rest zero
  output logic                   m_axis_tlast_o
);

  localparam int AW = $clog2(DEPTH);

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;
  logic              res_valid, res_free;
  res_t              res, m_res;

  dqps_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dqps_seq #(.DEPTH(DEPTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .mode_i      (s_axis_tuser_i[MODE_W-1:0]),
    .value_i     (s_axis_tdata_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  dqps_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (m_res)
  );

  // output word packing
  assign m_axis_tdata_o = m_res.item;
  assign m_axis_tuser_o = {(TUSER_OUT_W - PART_W - STAT_W)'(0), m_res.status, m_res.part};
  assign m_axis_tlast_o = m_res.last;

endmodule
